// ----- design/rlsd_pkg.sv -----
// Package for the redundant limit switch debouncer.
// Holds widths, register indexes, reset values and the result record type.
// No dependencies.
`timescale 1ns / 1ps

package rlsd_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DBT_W   = 17;
  localparam int unsigned READS_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [READS_W-1:0] STABLE_READS = 8'd3;

  localparam logic [DBT_W-1:0] DEBOUNCE_MIN_US = 17'd1000;
  localparam logic [DBT_W-1:0] DEBOUNCE_MAX_US = 17'd100000;

  localparam logic [DBT_W-1:0]  DEBOUNCE_RESET_US  = 17'd10000;
  localparam logic [TIME_W-1:0] HEARTBEAT_RESET_US = 32'd1000000;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USE_SECOND    = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] report_time_us;
    logic              limit_active;
    logic              switch_one_active;
    logic              switch_two_active;
    logic              disagree_fault;
    logic [TIME_W-1:0] activation_total;
    logic [TIME_W-1:0] last_activation_us;
  } rlsd_result_t;

endpackage

// ----- design/rlsd_settle.sv -----
// Debounce tracker for one switch: previous level, change time and read count.
// Depends on rlsd_pkg.
`timescale 1ns / 1ps

module rlsd_settle (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         level,
  input  logic [rlsd_pkg::TIME_W-1:0]  now_us,
  input  logic [rlsd_pkg::DBT_W-1:0]   debounce_time_us,
  output logic                         stable
);
  import rlsd_pkg::*;

  logic               prev_r, prev_nxt;
  logic [TIME_W-1:0]  since_r, since_nxt;
  logic [READS_W-1:0] reads_r, reads_nxt;
  logic [TIME_W-1:0]  elapsed;
  logic               time_ok;
  logic               changed;

  assign changed = (level != prev_r);
  assign elapsed = now_us - since_r;
  assign time_ok = (elapsed >= {{(TIME_W-DBT_W){1'b0}}, debounce_time_us});
  assign stable  = !changed && time_ok && (reads_r >= STABLE_READS);

  always_comb begin
    prev_nxt  = prev_r;
    since_nxt = since_r;
    reads_nxt = reads_r;
    if (changed) begin
      prev_nxt  = level;
      since_nxt = now_us;
      reads_nxt = READS_W'(1);
    end else if (time_ok && (reads_r < STABLE_READS)) begin
      reads_nxt = reads_r + READS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b0;
      since_r <= '0;
      reads_r <= '0;
    end else if (en) begin
      prev_r  <= prev_nxt;
      since_r <= since_nxt;
      reads_r <= reads_nxt;
    end
  end

  // The count only climbs while below the limit, so it never passes it.
  a_reads_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    reads_r <= STABLE_READS)
    else $error("read count above limit");

  a_change_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    en && changed |=> reads_r == READS_W'(1) && since_r == $past(now_us))
    else $error("level change did not restart debounce");

  a_stable_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    stable |-> level == prev_r && reads_r == STABLE_READS)
    else $error("stable reported on unsettled switch");

endmodule

// ----- design/rlsd_combine.sv -----
// Combined limit state, disagreement fault, activation counter and report decision.
// Depends on rlsd_pkg.
`timescale 1ns / 1ps

module rlsd_combine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          update,
  input  logic                          use_two,
  input  logic                          level_one,
  input  logic                          level_two,
  input  logic [rlsd_pkg::TIME_W-1:0]   now_us,
  input  logic [rlsd_pkg::TIME_W-1:0]   heartbeat_us,
  output logic                          emit,
  output rlsd_pkg::rlsd_result_t        result
);
  import rlsd_pkg::*;

  logic              combined_r, combined_nxt;
  logic              fault_r, fault_nxt;
  logic [TIME_W-1:0] edge_count_r, edge_count_nxt;
  logic [TIME_W-1:0] edge_time_r, edge_time_nxt;
  logic              reported_r;
  logic [TIME_W-1:0] report_time_r;
  logic              next_level;
  logic [TIME_W-1:0] since_report;

  assign next_level   = use_two ? (level_one & level_two) : level_one;
  assign since_report = now_us - report_time_r;

  always_comb begin
    combined_nxt   = combined_r;
    fault_nxt      = fault_r;
    edge_count_nxt = edge_count_r;
    edge_time_nxt  = edge_time_r;
    if (update) begin
      combined_nxt = next_level;
      fault_nxt    = use_two && (level_one != level_two);
      if (next_level && !combined_r) begin
        edge_count_nxt = edge_count_r + TIME_W'(1);
        edge_time_nxt  = now_us;
      end
    end
  end

  assign emit = (combined_nxt != reported_r) || (since_report >= heartbeat_us);

  always_comb begin
    result.report_time_us     = now_us;
    result.limit_active       = combined_nxt;
    result.switch_one_active  = level_one;
    result.switch_two_active  = use_two & level_two;
    result.disagree_fault     = fault_nxt;
    result.activation_total   = edge_count_nxt;
    result.last_activation_us = edge_time_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      combined_r    <= 1'b0;
      fault_r       <= 1'b0;
      edge_count_r  <= '0;
      edge_time_r   <= '0;
      reported_r    <= 1'b0;
      report_time_r <= '0;
    end else if (en) begin
      combined_r   <= combined_nxt;
      fault_r      <= fault_nxt;
      edge_count_r <= edge_count_nxt;
      edge_time_r  <= edge_time_nxt;
      if (emit) begin
        reported_r    <= combined_nxt;
        report_time_r <= now_us;
      end
    end
  end

  a_rise_counts: assert property (@(posedge clk) disable iff (!rst_n)
    en && update && next_level && !combined_r
      |=> edge_count_r == TIME_W'($past(edge_count_r) + TIME_W'(1)))
    else $error("rising edge not counted");

  a_report_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    en && emit |=> reported_r == combined_r && report_time_r == $past(now_us))
    else $error("report bookkeeping not updated");

  a_fault_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    en && update && !use_two |=> !fault_r)
    else $error("fault set with one switch");

endmodule

// ----- design/redundant_limit_switch_debouncer_unit.sv -----
// Top level of the redundant limit switch debouncer: configuration registers,
// input register, result register. Depends on rlsd_pkg, rlsd_settle, rlsd_combine.
//
//   Channel | Direction | Handshake          | Payload
//   in_     | input     | in_valid/in_ready  | now_us, raw_level_one, raw_level_two
//   out_    | output    | out_valid/out_ready| report fields, one per reporting poll
//   cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
// A poll is captured into the input register and processed from there; a poll
// that reports loads the result register. One poll per cycle is sustained while
// the result register is free or being taken, or the poll does not report.
// A poll that reports waits in the input register while the result register is full
// and not being taken; polls with no report pass through regardless.
// Synchronous active-low reset returns all but the data registers to their defaults.
`timescale 1ns / 1ps

module redundant_limit_switch_debouncer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rlsd_pkg::TIME_W-1:0]       in_now_us,
  input  logic                              in_raw_level_one,
  input  logic                              in_raw_level_two,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rlsd_pkg::TIME_W-1:0]       out_report_time_us,
  output logic                              out_limit_active,
  output logic                              out_switch_one_active,
  output logic                              out_switch_two_active,
  output logic                              out_disagree_fault,
  output logic [rlsd_pkg::TIME_W-1:0]       out_activation_total,
  output logic [rlsd_pkg::TIME_W-1:0]       out_last_activation_us,
  input  logic                              cfg_we,
  input  logic [rlsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rlsd_pkg::TIME_W-1:0]       cfg_wdata
);
  import rlsd_pkg::*;

  logic [DBT_W-1:0]  debounce_r;
  logic [TIME_W-1:0] heartbeat_r;
  logic              invert_r;
  logic              use_two_r;
  logic [DBT_W-1:0]  cfg_dbt;

  logic              in_valid_r;
  logic [TIME_W-1:0] now_r;
  logic              raw_one_r;
  logic              raw_two_r;

  logic              out_valid_r;
  rlsd_result_t      out_data_r;

  logic         level_one;
  logic         level_two;
  logic         stable_one;
  logic         stable_two_raw;
  logic         stable_two;
  logic         emit;
  logic         out_free;
  logic         proc;
  rlsd_result_t result;

  // Configuration. Out-of-range debounce times are dropped.
  assign cfg_dbt = cfg_wdata[DBT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= DEBOUNCE_RESET_US;
      heartbeat_r <= HEARTBEAT_RESET_US;
      invert_r    <= 1'b0;
      use_two_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE_TIME: begin
          if (cfg_dbt >= DEBOUNCE_MIN_US && cfg_dbt <= DEBOUNCE_MAX_US) begin
            debounce_r <= cfg_dbt;
          end
        end
        REG_HEARTBEAT: heartbeat_r <= cfg_wdata;
        REG_INVERT:    invert_r    <= cfg_wdata[0];
        REG_USE_SECOND: use_two_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign level_one = raw_one_r ^ invert_r;
  assign level_two = raw_two_r ^ invert_r;

  assign out_free = !out_valid_r || out_ready;
  assign proc     = in_valid_r && (out_free || !emit);
  assign in_ready = !in_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_r     <= in_now_us;
      raw_one_r <= in_raw_level_one;
      raw_two_r <= in_raw_level_two;
    end
  end

  rlsd_settle u_settle_one (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (proc),
    .level            (level_one),
    .now_us           (now_r),
    .debounce_time_us (debounce_r),
    .stable           (stable_one)
  );

  // The second tracker holds its state while the switch is unused.
  rlsd_settle u_settle_two (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (proc && use_two_r),
    .level            (level_two),
    .now_us           (now_r),
    .debounce_time_us (debounce_r),
    .stable           (stable_two_raw)
  );

  assign stable_two = !use_two_r || stable_two_raw;

  rlsd_combine u_combine (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (proc),
    .update       (stable_one && stable_two),
    .use_two      (use_two_r),
    .level_one    (level_one),
    .level_two    (level_two),
    .now_us       (now_r),
    .heartbeat_us (heartbeat_r),
    .emit         (emit),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      out_data_r <= result;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_report_time_us     = out_data_r.report_time_us;
  assign out_limit_active       = out_data_r.limit_active;
  assign out_switch_one_active  = out_data_r.switch_one_active;
  assign out_switch_two_active  = out_data_r.switch_two_active;
  assign out_disagree_fault     = out_data_r.disagree_fault;
  assign out_activation_total   = out_data_r.activation_total;
  assign out_last_activation_us = out_data_r.last_activation_us;

  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> in_valid_r && now_r == $past(in_now_us))
    else $error("accepted poll not captured");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    proc && emit |-> !out_valid_r || out_ready)
    else $error("pending report overwritten");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !(proc && emit) |=> !out_valid_r)
    else $error("delivered report not cleared");

endmodule

// ----- verif/redundant_limit_switch_debouncer_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for redundant_limit_switch_debouncer_unit: a directed poll script,
// then random poll sequences. A behavioral model in this file checks every report.
// Depends on rlsd_pkg and the design sources.

module redundant_limit_switch_debouncer_unit_tb;
  import rlsd_pkg::*;

  localparam int RUN_LIMIT       = 1000000;
  localparam int NUM_PHASES      = 13;
  localparam int POLLS_PER_PHASE = 100;
  localparam int HOLD_PHASE      = 4;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 4;

  typedef enum bit {ROW_POLL, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [TIME_W-1:0]      now;
    logic                   one;
    logic                   two;
    logic [CFG_IDX_W-1:0]   idx;
    logic [TIME_W-1:0]      data;
    bit                     typed;
    rlsd_result_t           want;
  } script_row_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [TIME_W-1:0]    in_now_us = '0;
  logic                 in_raw_level_one = 1'b0;
  logic                 in_raw_level_two = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [TIME_W-1:0]    out_report_time_us;
  logic                 out_limit_active;
  logic                 out_switch_one_active;
  logic                 out_switch_two_active;
  logic                 out_disagree_fault;
  logic [TIME_W-1:0]    out_activation_total;
  logic [TIME_W-1:0]    out_last_activation_us;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DEBOUNCE_TIME;
  logic [TIME_W-1:0]    cfg_wdata = '0;

  // Model copy of the registers and of the debounce state.
  logic [DBT_W-1:0]   settle_time_q;
  logic [TIME_W-1:0]  heartbeat_us;
  logic               invert_q;
  logic               second_q;
  logic               sw_prev  [2];
  logic [TIME_W-1:0]  sw_since [2];
  logic [READS_W-1:0] sw_reads [2];
  logic               combined_q;
  logic               fault_q;
  logic [TIME_W-1:0]  edge_total_q;
  logic [TIME_W-1:0]  edge_at_q;
  logic               reported_q;
  logic [TIME_W-1:0]  reported_at_q;

  rlsd_result_t pending_reports[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int hold_off_cycles = 0;
  bit sender_gaps_on = 1'b1;
  bit receiver_stalls_on = 1'b1;

  redundant_limit_switch_debouncer_unit u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void reset_predictor();
    for (int i = 0; i < 2; i++) begin
      sw_prev[i]  = 1'b0;
      sw_since[i] = '0;
      sw_reads[i] = '0;
    end
    settle_time_q = DEBOUNCE_RESET_US;
    heartbeat_us  = HEARTBEAT_RESET_US;
    invert_q      = 1'b0;
    second_q      = 1'b0;
    combined_q    = 1'b0;
    fault_q       = 1'b0;
    edge_total_q  = '0;
    edge_at_q     = '0;
    reported_q    = 1'b0;
    reported_at_q = '0;
  endfunction

  // A level change restarts the switch; it settles only after the debounce time
  // and enough consecutive reads at the same level.
  function automatic logic settle_switch(int idx, logic lvl, logic [TIME_W-1:0] now);
    if (lvl != sw_prev[idx]) begin
      sw_prev[idx]  = lvl;
      sw_since[idx] = now;
      sw_reads[idx] = 8'd1;
      return 1'b0;
    end
    if (32'(now - sw_since[idx]) >= 32'(settle_time_q)) begin
      if (sw_reads[idx] < STABLE_READS) begin
        sw_reads[idx] = sw_reads[idx] + 8'd1;
        return 1'b0;
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void debounce_poll(logic [TIME_W-1:0] now, logic raw_one, logic raw_two);
    logic lvl_one;
    logic lvl_two;
    logic ok_one;
    logic ok_two;
    logic next_level;
    rlsd_result_t rep;
    lvl_one = raw_one ^ invert_q;
    lvl_two = raw_two ^ invert_q;
    ok_one = settle_switch(0, lvl_one, now);
    ok_two = second_q ? settle_switch(1, lvl_two, now) : 1'b1;
    if (ok_one && ok_two) begin
      next_level = second_q ? (lvl_one & lvl_two) : lvl_one;
      fault_q = second_q && (lvl_one != lvl_two);
      if (next_level && !combined_q) begin
        edge_total_q = edge_total_q + 32'd1;
        edge_at_q = now;
      end
      combined_q = next_level;
    end
    if (combined_q != reported_q || 32'(now - reported_at_q) >= heartbeat_us) begin
      rep.report_time_us     = now;
      rep.limit_active       = combined_q;
      rep.switch_one_active  = lvl_one;
      rep.switch_two_active  = second_q ? lvl_two : 1'b0;
      rep.disagree_fault     = fault_q;
      rep.activation_total   = edge_total_q;
      rep.last_activation_us = edge_at_q;
      pending_reports.push_back(rep);
      reported_q    = combined_q;
      reported_at_q = now;
    end
  endfunction

  function automatic script_row_t poll_row(logic [TIME_W-1:0] now, logic one, logic two,
                                           bit typed = 1'b0, rlsd_result_t want = '0);
    script_row_t row;
    row.kind  = ROW_POLL;
    row.now   = now;
    row.one   = one;
    row.two   = two;
    row.idx   = REG_DEBOUNCE_TIME;
    row.data  = '0;
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  function automatic script_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
    script_row_t row;
    row = poll_row('0, 1'b0, 1'b0);
    row.kind = ROW_WRITE;
    row.idx  = idx;
    row.data = data;
    return row;
  endfunction

  task automatic log_mismatch(string field, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
    mismatch_count++;
    $display("[%0t] mismatch in %s: got %0h, expected %0h", $time, field, got, want);
  endtask

  task automatic check_report();
    rlsd_result_t want;
    if (pending_reports.size() == 0) begin
      log_mismatch("unexpected report, report_time_us", out_report_time_us, '0);
      return;
    end
    want = pending_reports.pop_front();
    if (out_report_time_us != want.report_time_us)
      log_mismatch("report_time_us", out_report_time_us, want.report_time_us);
    if (out_limit_active != want.limit_active)
      log_mismatch("limit_active", 32'(out_limit_active), 32'(want.limit_active));
    if (out_switch_one_active != want.switch_one_active)
      log_mismatch("switch_one_active", 32'(out_switch_one_active),
                   32'(want.switch_one_active));
    if (out_switch_two_active != want.switch_two_active)
      log_mismatch("switch_two_active", 32'(out_switch_two_active),
                   32'(want.switch_two_active));
    if (out_disagree_fault != want.disagree_fault)
      log_mismatch("disagree_fault", 32'(out_disagree_fault), 32'(want.disagree_fault));
    if (out_activation_total != want.activation_total)
      log_mismatch("activation_total", out_activation_total, want.activation_total);
    if (out_last_activation_us != want.last_activation_us)
      log_mismatch("last_activation_us", out_last_activation_us, want.last_activation_us);
  endtask

  // Valid is left high after acceptance so back-to-back transactions never drop it.
  task automatic offer_poll(logic [TIME_W-1:0] now, logic one, logic two,
                            bit typed, rlsd_result_t want);
    int queued;
    in_valid         <= 1'b1;
    in_now_us        <= now;
    in_raw_level_one <= one;
    in_raw_level_two <= two;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    queued = pending_reports.size();
    debounce_poll(now, one, two);
    if (typed) begin
      if (pending_reports.size() > queued) void'(pending_reports.pop_back());
      pending_reports.push_back(want);
    end
  endtask

  task automatic pace_sender();
    int r;
    int gap;
    if (!sender_gaps_on) return;
    r = $urandom_range(0, 99);
    if (r < 70) gap = 0;
    else if (r < 96) gap = $urandom_range(1, 3);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Polls without a report leave no trace in the queue, so the task keeps clocking after
  // the queue is empty to let the pipeline empty before anything is reconfigured.
  task automatic drain_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DEBOUNCE_TIME: begin
        if (data[DBT_W-1:0] >= DEBOUNCE_MIN_US && data[DBT_W-1:0] <= DEBOUNCE_MAX_US)
          settle_time_q = data[DBT_W-1:0];
      end
      REG_HEARTBEAT: heartbeat_us = data;
      REG_INVERT: invert_q = data[0];
      REG_USE_SECOND: second_q = data[0];
      default: ;
    endcase
  endtask

  task automatic retune_block(int phase);
    int r;
    logic [TIME_W-1:0] dbt;
    logic [TIME_W-1:0] hb;
    r = $urandom_range(0, 99);
    if (r < 10) dbt = 32'(DEBOUNCE_MIN_US);
    else if (r < 20) dbt = 32'(DEBOUNCE_MAX_US);
    else if (r < 30) dbt = $urandom();
    else if (r < 35) dbt = $urandom_range(0, 999);
    else dbt = $urandom_range(1000, 100000);
    if (phase == 0 || $urandom_range(0, 3) != 0) write_reg(REG_DEBOUNCE_TIME, dbt);
    r = $urandom_range(0, 99);
    if (r < 15) hb = '0;
    else if (r < 25) hb = 32'd1;
    else if (r < 35) hb = '1;
    else hb = $urandom_range(32'(settle_time_q), 32'(settle_time_q) * 40);
    // Every poll reports while the sink holds off, so the block must back up.
    if (phase == HOLD_PHASE) hb = '0;
    if (phase == 0 || phase == HOLD_PHASE || $urandom_range(0, 3) != 0)
      write_reg(REG_HEARTBEAT, hb);
    if (phase == 0 || $urandom_range(0, 2) != 0) write_reg(REG_INVERT, $urandom());
    if (phase == 0 || $urandom_range(0, 2) != 0) write_reg(REG_USE_SECOND, $urandom());
  endtask

  initial begin : result_sink
    int stall_left;
    int r;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) check_report();
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
        out_ready <= 1'b1;
      end else if (!receiver_stalls_on) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          stall_left = $urandom_range(10, 40);
          out_ready <= 1'b0;
        end else begin
          out_ready <= (r >= 18);
        end
      end
    end
  end

  initial begin : stimulus
    script_row_t script[$];
    logic [TIME_W-1:0] poll_time;
    logic raw_one;
    logic raw_two;
    bit stuck_two;
    int r;
    reset_predictor();

    // Startup from time zero, then a first activation with the reset settings.
    script.push_back(poll_row(32'd0, 1'b0, 1'b0));
    script.push_back(poll_row(32'd1000000, 1'b0, 1'b0, 1'b1,
                     rlsd_result_t'{32'd1000000, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}));
    script.push_back(poll_row(32'd1010000, 1'b0, 1'b0));
    script.push_back(poll_row(32'd1020000, 1'b0, 1'b0));
    script.push_back(poll_row(32'd1030000, 1'b0, 1'b0));
    script.push_back(poll_row(32'd1040000, 1'b1, 1'b0));
    script.push_back(poll_row(32'd1050000, 1'b1, 1'b0));
    script.push_back(poll_row(32'd1060000, 1'b1, 1'b0));
    script.push_back(poll_row(32'd1070000, 1'b1, 1'b0, 1'b1,
                     rlsd_result_t'{32'd1070000, 1'b1, 1'b1, 1'b0, 1'b0, 32'd1, 32'd1070000}));
    script.push_back(poll_row(32'hFFFF_FFFF, 1'b1, 1'b1));
    script.push_back(poll_row(32'd0, 1'b0, 1'b1));
    // Heartbeat of zero reports every poll; inverted levels, both switches, shortest debounce.
    script.push_back(reg_row(REG_HEARTBEAT, 32'd0));
    script.push_back(reg_row(REG_INVERT, 32'd1));
    script.push_back(reg_row(REG_USE_SECOND, 32'd1));
    script.push_back(reg_row(REG_DEBOUNCE_TIME, 32'(DEBOUNCE_MIN_US)));
    script.push_back(poll_row(32'd1000, 1'b0, 1'b0));
    script.push_back(poll_row(32'd2000, 1'b0, 1'b1));
    script.push_back(poll_row(32'd3000, 1'b0, 1'b1));
    script.push_back(poll_row(32'd4000, 1'b0, 1'b1));
    script.push_back(poll_row(32'd5000, 1'b0, 1'b1));
    // Out-of-range debounce writes are dropped; upper data bits are not part of the field.
    script.push_back(reg_row(REG_DEBOUNCE_TIME, 32'd999));
    script.push_back(reg_row(REG_DEBOUNCE_TIME, 32'd100001));
    script.push_back(reg_row(REG_DEBOUNCE_TIME, 32'h0001_FFFF));
    script.push_back(reg_row(REG_DEBOUNCE_TIME, 32'hFFFE_0000 | 32'(DEBOUNCE_MAX_US)));
    script.push_back(reg_row(REG_HEARTBEAT, 32'hFFFF_FFFF));
    script.push_back(reg_row(REG_USE_SECOND, 32'd0));
    // Second switch off: its level is ignored and its state is held.
    script.push_back(poll_row(32'h0001_0000, 1'b1, 1'b0));
    script.push_back(poll_row(32'h0003_0000, 1'b1, 1'b1));
    script.push_back(poll_row(32'h0005_0000, 1'b1, 1'b0));
    script.push_back(poll_row(32'h0007_0000, 1'b1, 1'b1));
    script.push_back(poll_row(32'h0009_0000, 1'b0, 1'b1));
    script.push_back(reg_row(REG_USE_SECOND, 32'd1));
    script.push_back(reg_row(REG_INVERT, 32'd0));
    script.push_back(poll_row(32'h7FFF_FFFF, 1'b1, 1'b1));
    script.push_back(poll_row(32'h8001_86A0, 1'b1, 1'b1));
    script.push_back(poll_row(32'h8003_0000, 1'b1, 1'b1));
    script.push_back(poll_row(32'h8005_0000, 1'b1, 1'b1));
    script.push_back(poll_row(32'hFFFF_FFFE, 1'b1, 1'b1));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        drain_reports();
        write_reg(script[i].idx, script[i].data);
      end else begin
        offer_poll(script[i].now, script[i].one, script[i].two, script[i].typed, script[i].want);
        pace_sender();
      end
    end

    poll_time = $urandom();
    raw_one = 1'b0;
    raw_two = 1'b0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_reports();
      retune_block(ph);
      sender_gaps_on     = ($urandom_range(0, 9) < 7) && (ph != HOLD_PHASE);
      receiver_stalls_on = ($urandom_range(0, 9) < 7);
      stuck_two = ($urandom_range(0, 3) == 0);
      raw_two = 1'($urandom_range(0, 1));
      if (ph == HOLD_PHASE) hold_off_cycles = HOLD_CYCLES;
      for (int k = 0; k < POLLS_PER_PHASE; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          poll_time = $urandom();
        end else if (r < 6) begin
          poll_time = poll_time + $urandom();
        end else if (r < 20) begin
          // Contact bounce: closely spaced polls with erratic levels.
          poll_time = poll_time + $urandom_range(0, 60);
          if ($urandom_range(0, 1) == 1) raw_one = !raw_one;
        end else begin
          poll_time = poll_time + $urandom_range(32'(settle_time_q) / 4,
                                                 32'(settle_time_q) / 2);
          if ($urandom_range(0, 99) < 5) raw_one = !raw_one;
        end
        if (!stuck_two)
          raw_two = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : raw_one;
        offer_poll(poll_time, raw_one, raw_two, 1'b0, '0);
        pace_sender();
      end
    end

    drain_reports();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/rlsd_pkg.sv
design/rlsd_settle.sv
design/rlsd_combine.sv
design/redundant_limit_switch_debouncer_unit.sv
verif/redundant_limit_switch_debouncer_unit_tb.sv
